/* rtl/wsfd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Shared parse phase codes and the result flag bundle of the deframer.
// ----------------------------------------------------------------------------
package wsfd_pkg;

  // Parse phase codes.
  localparam logic [2:0] PH_HDR1 = 3'd0;
  localparam logic [2:0] PH_HDR2 = 3'd1;
  localparam logic [2:0] PH_EXT  = 3'd2;
  localparam logic [2:0] PH_KEY  = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;

  // Second header byte length codes and counts.
  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;
  localparam logic [3:0] EXT_BYTES_16 = 4'd2;
  localparam logic [3:0] EXT_BYTES_64 = 4'd8;
  localparam logic [3:0] KEY_BYTES    = 4'd4;

  // Fixed-width fields of one result transaction.
  typedef struct packed {
    logic       has_byte;
    logic [7:0] payload_byte;
    logic       frame_fin;
    logic [3:0] frame_opcode;
    logic       frame_masked;
    logic       last_of_frame;
  } res_flags_t;

endpackage : wsfd_pkg
`default_nettype wire

/* rtl/websocket_frame_deframer_unit.sv */
// A result appears in the output register in the cycle after its byte is accepted.
// Throughput: one byte per cycle; header bytes give no result transaction, except the empty-frame marker.
// The input stalls only while a held result is not taken downstream.
// Reset (synchronous): the parser expects the first header byte and all frame
// state is cleared; the output register is emptied.
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses frame headers from a byte stream and emits unmasked payload bytes.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_unit
  import wsfd_pkg::*;
#(
  parameter int LENGTH_BITS = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   data_valid,
  output logic                        data_ready,
  input  wire logic [7:0]             data_byte,
  output logic                        result_valid,
  input  wire logic                   result_ready,
  output logic                        has_byte,
  output logic [7:0]                  payload_byte,
  output logic                        frame_fin,
  output logic [3:0]                  frame_opcode,
  output logic                        frame_masked,
  output logic [LENGTH_BITS-1:0]      payload_length,
  output logic                        last_of_frame
);

  logic                   accept;
  logic                   res_valid;
  res_flags_t             res_flags;
  logic [LENGTH_BITS-1:0] res_length;
  res_flags_t             out_flags;

  assign accept = data_valid && data_ready;

  // Header parsing and unmasking.
  wsfd_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (data_byte),
    .res_valid  (res_valid),
    .res_flags  (res_flags),
    .res_length (res_length)
  );

  // Result register between the parser and the downstream side.
  wsfd_out_reg #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (data_valid),
    .in_ready   (data_ready),
    .res_valid  (res_valid),
    .res_flags  (res_flags),
    .res_length (res_length),
    .out_valid  (result_valid),
    .out_ready  (result_ready),
    .out_flags  (out_flags),
    .out_length (payload_length)
  );

  // Unpack the held result onto the output ports.
  assign has_byte      = out_flags.has_byte;
  assign payload_byte  = out_flags.payload_byte;
  assign frame_fin     = out_flags.frame_fin;
  assign frame_opcode  = out_flags.frame_opcode;
  assign frame_masked  = out_flags.frame_masked;
  assign last_of_frame = out_flags.last_of_frame;

endmodule : websocket_frame_deframer_unit
`default_nettype wire

/* rtl/wsfd_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket deframer header parser
// Holds the frame state, decodes header bytes and unmasks payload bytes.
// ----------------------------------------------------------------------------
module wsfd_parser
  import wsfd_pkg::*;
#(
  parameter int LENGTH_BITS = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   accept,
  input  wire logic [7:0]             data_byte,
  output logic                        res_valid,
  output res_flags_t                  res_flags,
  output logic [LENGTH_BITS-1:0]      res_length
);

  logic [2:0]             phase, phase_next;
  logic [3:0]             ext_count, ext_count_next;
  logic [LENGTH_BITS-1:0] length_accum, length_accum_next;
  logic [LENGTH_BITS-1:0] remaining, remaining_next;
  logic [31:0]            mask_key, mask_key_next;
  logic [1:0]             key_index, key_index_next;
  logic                   cur_fin, cur_fin_next;
  logic [3:0]             cur_opcode, cur_opcode_next;
  logic                   cur_masked, cur_masked_next;

  logic                   len_done;
  logic                   hdr_done;
  logic                   has_byte;
  logic                   last;
  logic [7:0]             key_byte;
  logic [LENGTH_BITS-1:0] remaining_dec;

  // Key byte for the current payload position, first key byte in the top bits.
  always_comb begin
    case (key_index)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  // Remaining count steps down but never below zero.
  assign remaining_dec = (remaining != '0) ? remaining - 1'b1 : remaining;

  // Next-state and result logic for one accepted byte.
  always_comb begin
    phase_next        = phase;
    ext_count_next    = ext_count;
    length_accum_next = length_accum;
    remaining_next    = remaining;
    mask_key_next     = mask_key;
    key_index_next    = key_index;
    cur_fin_next      = cur_fin;
    cur_opcode_next   = cur_opcode;
    cur_masked_next   = cur_masked;
    len_done          = 1'b0;
    hdr_done          = 1'b0;
    res_valid         = 1'b0;
    has_byte          = 1'b0;
    last              = 1'b0;

    case (phase)
      PH_HDR2: begin
        cur_masked_next   = data_byte[7];
        length_accum_next = '0;
        if (data_byte[6:0] == LEN_CODE_16) begin
          ext_count_next = EXT_BYTES_16;
          phase_next     = PH_EXT;
        end else if (data_byte[6:0] == LEN_CODE_64) begin
          ext_count_next = EXT_BYTES_64;
          phase_next     = PH_EXT;
        end else begin
          length_accum_next = {{(LENGTH_BITS-7){1'b0}}, data_byte[6:0]};
          len_done          = 1'b1;
        end
      end
      PH_EXT: begin
        // Saturate once the shift would push set bits out of the top.
        if (length_accum[LENGTH_BITS-1 -: 8] != 8'd0) begin
          length_accum_next = '1;
        end else begin
          length_accum_next = {length_accum[LENGTH_BITS-9:0], data_byte};
        end
        ext_count_next = ext_count - 1'b1;
        len_done       = (ext_count_next == 4'd0);
      end
      PH_KEY: begin
        mask_key_next  = {mask_key[23:0], data_byte};
        ext_count_next = ext_count - 1'b1;
        hdr_done       = (ext_count_next == 4'd0);
      end
      PH_DATA: begin
        key_index_next = key_index + 1'b1;
        remaining_next = remaining_dec;
        last           = (remaining_dec == '0);
        if (last) begin
          phase_next = PH_HDR1;
        end
        res_valid = 1'b1;
        has_byte  = 1'b1;
      end
      default: begin
        cur_fin_next    = data_byte[7];
        cur_opcode_next = data_byte[3:0];
        phase_next      = PH_HDR2;
      end
    endcase

    // Length known: collect the key or finish the header.
    if (len_done) begin
      if (cur_masked_next) begin
        mask_key_next  = '0;
        ext_count_next = KEY_BYTES;
        phase_next     = PH_KEY;
      end else begin
        hdr_done = 1'b1;
      end
    end

    // Header finished: start the payload or give the empty-frame marker.
    if (hdr_done) begin
      key_index_next = 2'd0;
      if (length_accum_next == '0) begin
        phase_next = PH_HDR1;
        res_valid  = 1'b1;
        last       = 1'b1;
      end else begin
        remaining_next = length_accum_next;
        phase_next     = PH_DATA;
      end
    end
  end

  // Result fields as the frame state stands after this byte.
  always_comb begin
    res_flags.has_byte      = has_byte;
    res_flags.payload_byte  = has_byte ? (data_byte ^ (cur_masked ? key_byte : 8'd0)) : 8'd0;
    res_flags.frame_fin     = cur_fin_next;
    res_flags.frame_opcode  = cur_opcode_next;
    res_flags.frame_masked  = cur_masked_next;
    res_flags.last_of_frame = last;
    res_length              = length_accum_next;
  end

  // Frame state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HDR1;
      ext_count    <= 4'd0;
      length_accum <= '0;
      remaining    <= '0;
      mask_key     <= '0;
      key_index    <= 2'd0;
      cur_fin      <= 1'b0;
      cur_opcode   <= 4'd0;
      cur_masked   <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      ext_count    <= ext_count_next;
      length_accum <= length_accum_next;
      remaining    <= remaining_next;
      mask_key     <= mask_key_next;
      key_index    <= key_index_next;
      cur_fin      <= cur_fin_next;
      cur_opcode   <= cur_opcode_next;
      cur_masked   <= cur_masked_next;
    end
  end

  // The byte counter is never zero while length or key bytes are expected.
  a_count_live: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_EXT || phase == PH_KEY) |-> ext_count != 4'd0)
    else $error("byte counter empty during extended length or key");

  // The final payload byte returns the parser to the first header byte.
  a_data_end: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_DATA && remaining == {{(LENGTH_BITS-1){1'b0}}, 1'b1}
    |=> phase == PH_HDR1)
    else $error("parser did not leave payload after last byte");

  // Payload always starts at key byte zero.
  a_key_start: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_KEY && ext_count == 4'd1 |=> key_index == 2'd0)
    else $error("key index not cleared at payload start");

endmodule : wsfd_parser
`default_nettype wire

/* rtl/wsfd_out_reg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket deframer output register
// Holds one result transaction and decides when a new byte may enter.
// ----------------------------------------------------------------------------
module wsfd_out_reg
  import wsfd_pkg::*;
#(
  parameter int LENGTH_BITS = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   res_valid,
  input  wire res_flags_t             res_flags,
  input  wire logic [LENGTH_BITS-1:0] res_length,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output res_flags_t                  out_flags,
  output logic [LENGTH_BITS-1:0]      out_length
);

  logic load;

  // A byte enters whenever the held result is absent or leaving.
  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  // Valid flag of the held result.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      out_flags  <= res_flags;
      out_length <= res_length;
    end
  end

  // A result produced by an accepted byte is offered in the next cycle.
  a_res_shown: assert property (@(posedge clk) disable iff (rst)
    load && res_valid |=> out_valid)
    else $error("result lost in output register");

endmodule : wsfd_out_reg
`default_nettype wire
